>>> design/rnts_pkg.sv
// shared constants, request types and the query folding function for the name table search
`default_nettype none
package rnts_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int NAME_LEN    = 8;
  localparam int NAME_W      = 8 * NAME_LEN;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [NAME_W-1:0] data;
  } rnts_wr_req_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rnts_rd_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } rnts_result_t;

  // zero everything after the first nul byte and fold a-z to upper case
  function automatic logic [NAME_W-1:0] fold_query(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic [7:0]        ch;
    logic              ended;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_LEN; i++) begin
      ch = raw[8*i +: 8];
      if (ch == 8'h00) begin
        ended = 1'b1;
      end
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
        ch = ch - CASE_OFFSET;
      end
      if (!ended) begin
        res[8*i +: 8] = ch;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/rnts_name_mem.sv
// name table storage: one write port and one registered read port
`default_nettype none
module rnts_name_mem
  import rnts_pkg::*;
(
  input  wire logic              clk,
  input  wire rnts_wr_req_t      wr,
  input  wire rnts_rd_req_t      rd,
  output logic [NAME_W-1:0]      rd_data
);

  logic [NAME_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule
`default_nettype wire

>>> design/rnts_scanner.sv
// lookup sequencer: walks the table downward through one shared 64-bit compare
`default_nettype none
module rnts_scanner
  import rnts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NAME_W-1:0] query_raw,
  input  wire logic [CNT_W-1:0]  entry_count,
  input  wire logic [NAME_W-1:0] rd_data,
  input  wire logic              out_free,
  output rnts_rd_req_t           rd_req,
  output rnts_result_t           res,
  output logic                   res_push,
  output logic                   busy
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t            state, state_next;
  logic              cmp_valid, cmp_valid_next;
  logic [NAME_W-1:0] query, query_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next;
  logic [CNT_W-1:0]  rd_left, rd_left_next;
  logic [IDX_W-1:0]  cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0]  scan_count, scan_count_next;
  logic              res_found, res_found_next;
  logic [IDX_W-1:0]  res_index, res_index_next;
  logic [CNT_W-1:0]  count_sat;
  logic              hit;

  assign count_sat = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
  assign hit       = cmp_valid && (rd_data == query);

  always_comb begin
    state_next      = state;
    cmp_valid_next  = 1'b0;
    query_next      = query;
    rd_idx_next     = rd_idx;
    rd_left_next    = rd_left;
    cmp_idx_next    = cmp_idx;
    scan_count_next = scan_count;
    res_found_next  = res_found;
    res_index_next  = res_index;
    rd_req.en       = 1'b0;
    rd_req.addr     = rd_idx;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          query_next      = fold_query(query_raw);
          scan_count_next = count_sat;
          rd_idx_next     = IDX_W'(count_sat - CNT_W'(1));
          rd_left_next    = count_sat;
          res_found_next  = 1'b0;
          res_index_next  = '0;
          state_next      = (count_sat == '0) ? ST_HOLD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare the word read the cycle before
        if (rd_left != '0) begin
          rd_req.en      = 1'b1;
          rd_idx_next    = rd_idx - IDX_W'(1);
          rd_left_next   = rd_left - CNT_W'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = rd_idx;
        end
        if (hit) begin
          res_found_next = 1'b1;
          res_index_next = cmp_idx;
          cmp_valid_next = 1'b0;
          state_next     = ST_HOLD;
        end else if (rd_left == '0) begin
          cmp_valid_next = 1'b0;
          state_next     = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    query      <= query_next;
    rd_idx     <= rd_idx_next;
    rd_left    <= rd_left_next;
    cmp_idx    <= cmp_idx_next;
    scan_count <= scan_count_next;
    res_found  <= res_found_next;
    res_index  <= res_index_next;
  end

  assign res.found = res_found;
  assign res.index = res_index;
  assign res_push  = (state == ST_HOLD) && out_free;
  assign busy      = (state != ST_IDLE);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == ST_IDLE)
    else $error("lookup started while scanner busy");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> rd_left <= scan_count)
    else $error("remaining entry count above scan length");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cmp_valid) |-> ({1'b0, cmp_idx} < scan_count))
    else $error("compared entry outside the searched range");

  a_push_then_idle: assert property (@(posedge clk) disable iff (rst)
    res_push |=> state == ST_IDLE)
    else $error("scanner did not return to idle after result");

  a_cmp_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> $past(state) == ST_SCAN)
    else $error("compare stage active outside a scan");
`endif

endmodule
`default_nettype wire

>>> design/reverse_name_table_search_unit.sv
// Reverse name table search: a table of 8-byte names searched from the top entry down.
// Request channel (req_valid / req_stall): mode 0 stores name_bytes at entry_index and
// gives no result; mode 1 looks up name_bytes, folded to upper case and cut at the first
// nul byte, and gives one result on the response channel.
// Response channel (rsp_valid / rsp_stall): found and match_index of the highest matching
// entry below entry_count; match_index is 0 when nothing matched.
// Configuration channel (cfg_valid / cfg_ready): writes entry_count, values above the table
// depth scan the whole table. Write it only while no lookup is in flight.
// A lookup reads the table through its single read port, one entry per cycle, and stops
// early when a match is found. req_stall stays high until the result moves into the output
// register, so the next request is taken in the cycle the response appears at the earliest.
// The response sits in an output register; a new request is taken while it waits, but a
// finished lookup holds until the register is free.
// Reset clears entry_count to 0 and empties the response register. Table contents are not
// cleared: every entry must be written before a lookup scans it.
`default_nettype none
module reverse_name_table_search_unit
  import rnts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire logic              mode,
  input  wire logic [IDX_W-1:0]  entry_index,
  input  wire logic [NAME_W-1:0] name_bytes,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output logic                   found,
  output logic [IDX_W-1:0]       match_index,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_data
);

  logic              req_take;
  logic              busy;
  logic              out_free;
  logic              res_push;
  logic [CNT_W-1:0]  entry_count;
  logic [NAME_W-1:0] rd_data;
  rnts_wr_req_t      wr_req;
  rnts_rd_req_t      rd_req;
  rnts_result_t      res;

  assign req_stall = busy;
  assign req_take  = req_valid && !busy;
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // slots past the table depth are dropped
  assign wr_req.en   = req_take && (mode == MODE_WRITE)
                       && ({1'b0, entry_index} < (IDX_W + 1)'(MAX_ENTRIES));
  assign wr_req.addr = entry_index;
  assign wr_req.data = name_bytes;

  rnts_name_mem u_mem (
    .clk     (clk),
    .wr      (wr_req),
    .rd      (rd_req),
    .rd_data (rd_data)
  );

  rnts_scanner u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (req_take && (mode == MODE_LOOKUP)),
    .query_raw   (name_bytes),
    .entry_count (entry_count),
    .rd_data     (rd_data),
    .out_free    (out_free),
    .rd_req      (rd_req),
    .res         (res),
    .res_push    (res_push),
    .busy        (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_push) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      found       <= res.found;
      match_index <= res.index;
    end
  end

endmodule
`default_nettype wire
